// ===== hw/rtl/cfr_pkg.sv =====
// Shared types, codes and sizes for the chunked frame reassembler.
// Used by the front, queue, back, top level and checker; depends on nothing.
`default_nettype none

package cfr_pkg;

    // Largest frame the store holds, in bytes.
    localparam int MAX_FRAME = 65536;
    localparam int ADDR_W    = $clog2(MAX_FRAME);
    localparam int POS_W     = $clog2(MAX_FRAME + 1);
    localparam int COUNT_OUT_W = 17;
    localparam int STORE_W   = 9;

    localparam logic [31:0] HDR_MAGIC = 32'h31474D4A;
    localparam logic [16:0] HDR_BYTES = 17'd18;

    localparam logic [1:0] FN_HDR  = 2'd0;
    localparam logic [1:0] FN_PAY  = 2'd1;
    localparam logic [1:0] FN_READ = 2'd2;

    typedef enum logic [2:0] {
        STS_HDR_SAME = 3'd0,
        STS_HDR_NEW  = 3'd1,
        STS_HDR_REJ  = 3'd2,
        STS_STORED   = 3'd3,
        STS_DUP      = 3'd4,
        STS_DROP     = 3'd5,
        STS_READ     = 3'd6
    } status_e;

    typedef enum logic [2:0] {
        RSN_NONE     = 3'd0,
        RSN_SHORT    = 3'd1,
        RSN_MAGIC    = 3'd2,
        RSN_ZERO     = 3'd3,
        RSN_PKT      = 3'd4,
        RSN_SIZE     = 3'd5,
        RSN_BEYOND   = 3'd6
    } reason_e;

    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_HDR_BAD = 3'd1,
        OP_HDR_OK  = 3'd2,
        OP_PAY     = 3'd3,
        OP_READ    = 3'd4
    } op_e;

    typedef enum logic [1:0] {
        S_CLEAR    = 2'd0,
        S_IDLE     = 2'd1,
        S_PAY_WAIT = 2'd2,
        S_RD_WAIT  = 2'd3
    } state_e;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        op_e               op;
        reason_e           reason;
        logic [31:0]       frame_num;
        logic [POS_W-1:0]  fsize;
        logic [POS_W-1:0]  offset;
        logic [15:0]       csize;
        logic [7:0]        data;
        logic [ADDR_W-1:0] raddr;
        logic              raddr_ok;
    } cmd_t;

    // Handshake and status from the back to the queue and the top level.
    typedef struct packed {
        logic pop;
        logic init_busy;
    } back_stat_t;

    function automatic logic [COUNT_OUT_W-1:0] cnt_out(input logic [POS_W-1:0] v);
        logic [POS_W+COUNT_OUT_W-1:0] w;
        w = {{COUNT_OUT_W{1'b0}}, v};
        return w[COUNT_OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cfr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package is used.
`default_nettype none

module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cfr_front.sv =====
// Front end: accepts an input beat and classifies it, running the header checks.
// Depends on cfr_pkg.
`default_nettype none

module cfr_front (
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  func,
    input  wire logic [15:0] packet_len,
    input  wire logic [31:0] magic_word,
    input  wire logic [31:0] frame_number,
    input  wire logic [31:0] frame_size,
    input  wire logic [31:0] chunk_offset,
    input  wire logic [15:0] chunk_size,
    input  wire logic [7:0]  payload_byte,
    input  wire logic [15:0] read_addr,
    output logic             push,
    output cfr_pkg::cmd_t    cmd
);

    logic [16:0] hdr_plus_chunk;
    logic [32:0] chunk_end;
    logic        size_bad;
    logic [cfr_pkg::ADDR_W+15:0] raddr_wide;
    cfr_pkg::reason_e reason;

    assign push = start && !busy;

    always_comb
    begin
        hdr_plus_chunk = cfr_pkg::HDR_BYTES + {1'b0, chunk_size};
        // The end of the chunk is formed one bit wider so it never wraps.
        chunk_end = {1'b0, chunk_offset} + {17'd0, chunk_size};
        size_bad = (frame_size == 32'd0) || ({1'b0, frame_size} > 33'(cfr_pkg::MAX_FRAME));

        if ({1'b0, packet_len} < cfr_pkg::HDR_BYTES)
            reason = cfr_pkg::RSN_SHORT;
        else if (magic_word != cfr_pkg::HDR_MAGIC)
            reason = cfr_pkg::RSN_MAGIC;
        else if (chunk_size == 16'd0)
            reason = cfr_pkg::RSN_ZERO;
        else if (hdr_plus_chunk > {1'b0, packet_len})
            reason = cfr_pkg::RSN_PKT;
        else if (size_bad)
            reason = cfr_pkg::RSN_SIZE;
        else if (chunk_end > {1'b0, frame_size})
            reason = cfr_pkg::RSN_BEYOND;
        else
            reason = cfr_pkg::RSN_NONE;

        raddr_wide = {{cfr_pkg::ADDR_W{1'b0}}, read_addr};

        cmd.reason    = cfr_pkg::RSN_NONE;
        cmd.frame_num = frame_number;
        cmd.fsize     = frame_size[cfr_pkg::POS_W-1:0];
        cmd.offset    = chunk_offset[cfr_pkg::POS_W-1:0];
        cmd.csize     = chunk_size;
        cmd.data      = payload_byte;
        cmd.raddr     = raddr_wide[cfr_pkg::ADDR_W-1:0];
        cmd.raddr_ok  = {16'd0, read_addr} < 32'(cfr_pkg::MAX_FRAME);

        case (func)
            cfr_pkg::FN_HDR:
            begin
                cmd.reason = reason;
                cmd.op = (reason == cfr_pkg::RSN_NONE) ? cfr_pkg::OP_HDR_OK
                                                       : cfr_pkg::OP_HDR_BAD;
            end
            cfr_pkg::FN_PAY:  cmd.op = cfr_pkg::OP_PAY;
            cfr_pkg::FN_READ: cmd.op = cfr_pkg::OP_READ;
            default:          cmd.op = cfr_pkg::OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cfr_queue.sv =====
// Two-entry queue of classified items between the front and the back.
// Depends on cfr_pkg.
`default_nettype none

module cfr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  cfr_pkg::cmd_t      cmd_in,
    input  wire logic          pop,
    output logic               valid,
    output logic               full,
    output cfr_pkg::cmd_t      cmd_out
);

    cfr_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign valid   = fill_reg != 2'd0;
    assign full    = fill_reg == 2'd2;
    assign cmd_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 2'd1;
        else if (pop && !push)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cfr_back.sv =====
// Back end: frame state, byte store sweeps, payload stores and reads, result registers.
// Depends on cfr_pkg and cfr_ram.
`default_nettype none

module cfr_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  cfr_pkg::cmd_t        cmd,
    output cfr_pkg::back_stat_t  stat,
    output logic                 done,
    output logic [2:0]           status,
    output logic [2:0]           reject_reason,
    output logic                 frame_complete,
    output logic [31:0]          current_frame,
    output logic [16:0]          bytes_received,
    output logic                 frame_ready,
    output logic [7:0]           read_data
);

    localparam int AW = cfr_pkg::ADDR_W;
    localparam int PW = cfr_pkg::POS_W;

    cfr_pkg::state_e  state_reg;
    cfr_pkg::state_e  state_next;
    logic [31:0]      active_id_reg;
    logic [31:0]      active_id_next;
    logic [PW-1:0]    expected_reg;
    logic [PW-1:0]    expected_next;
    logic [PW-1:0]    count_reg;
    logic [PW-1:0]    count_next;
    logic [PW-1:0]    wpos_reg;
    logic [PW-1:0]    wpos_next;
    logic [15:0]      left_reg;
    logic [15:0]      left_next;
    logic             ready_flag_reg;
    logic             ready_flag_next;
    logic             init_reg;
    logic             init_next;
    logic [AW-1:0]    clr_addr_reg;
    logic [AW-1:0]    clr_addr_next;
    logic [7:0]       pay_byte_reg;
    logic [7:0]       pay_byte_next;

    logic             done_reg;
    logic             done_next;
    cfr_pkg::status_e res_status_reg;
    cfr_pkg::status_e res_status_next;
    cfr_pkg::reason_e res_reason_reg;
    cfr_pkg::reason_e res_reason_next;
    logic             res_complete_reg;
    logic             res_complete_next;
    logic [7:0]       res_data_reg;
    logic [7:0]       res_data_next;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [cfr_pkg::STORE_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [cfr_pkg::STORE_W-1:0] ram_rdata;

    logic          new_frame;
    logic          pos_ok;
    logic          clr_last;
    logic          stored;
    logic [PW-1:0] count_inc;
    logic [15:0]   left_dec;

    // Each store word is {received bit, byte}.
    cfr_ram #(
        .WIDTH (cfr_pkg::STORE_W),
        .DEPTH (cfr_pkg::MAX_FRAME)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign new_frame = (cmd.frame_num != active_id_reg) || (cmd.fsize != expected_reg);
    assign pos_ok    = wpos_reg < PW'(cfr_pkg::MAX_FRAME);
    assign clr_last  = clr_addr_reg == AW'(cfr_pkg::MAX_FRAME - 1);
    assign stored    = !ram_rdata[cfr_pkg::STORE_W-1];
    assign count_inc = count_reg + {{(PW-1){1'b0}}, stored};
    assign left_dec  = left_reg - 16'd1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cfr_pkg::S_CLEAR:
            begin
                if (clr_last)
                    state_next = cfr_pkg::S_IDLE;
            end
            cfr_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    case (cmd.op)
                        cfr_pkg::OP_HDR_OK:
                        begin
                            if (new_frame)
                                state_next = cfr_pkg::S_CLEAR;
                        end
                        cfr_pkg::OP_PAY:
                        begin
                            if (left_reg != 16'd0 && pos_ok)
                                state_next = cfr_pkg::S_PAY_WAIT;
                        end
                        cfr_pkg::OP_READ:
                        begin
                            if (cmd.raddr_ok)
                                state_next = cfr_pkg::S_RD_WAIT;
                        end
                        default: state_next = cfr_pkg::S_IDLE;
                    endcase
                end
            end
            cfr_pkg::S_PAY_WAIT: state_next = cfr_pkg::S_IDLE;
            cfr_pkg::S_RD_WAIT:  state_next = cfr_pkg::S_IDLE;
            default:             state_next = cfr_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        active_id_next    = active_id_reg;
        expected_next     = expected_reg;
        count_next        = count_reg;
        wpos_next         = wpos_reg;
        left_next         = left_reg;
        ready_flag_next   = ready_flag_reg;
        init_next         = init_reg;
        clr_addr_next     = clr_addr_reg;
        pay_byte_next     = pay_byte_reg;
        done_next         = 1'b0;
        res_status_next   = res_status_reg;
        res_reason_next   = cfr_pkg::RSN_NONE;
        res_complete_next = 1'b0;
        res_data_next     = 8'd0;
        ram_we            = 1'b0;
        ram_waddr         = clr_addr_reg;
        ram_wdata         = '0;
        ram_re            = 1'b0;
        ram_raddr         = wpos_reg[AW-1:0];
        stat.pop          = 1'b0;
        stat.init_busy    = init_reg;

        case (state_reg)
            cfr_pkg::S_CLEAR:
            begin
                ram_we = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_last)
                begin
                    clr_addr_next = '0;
                    init_next = 1'b0;
                end
            end
            cfr_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    stat.pop = 1'b1;
                    pay_byte_next = cmd.data;
                    case (cmd.op)
                        cfr_pkg::OP_HDR_BAD:
                        begin
                            left_next = 16'd0;
                            done_next = 1'b1;
                            res_status_next = cfr_pkg::STS_HDR_REJ;
                            res_reason_next = cmd.reason;
                        end
                        cfr_pkg::OP_HDR_OK:
                        begin
                            wpos_next = cmd.offset;
                            left_next = cmd.csize;
                            done_next = 1'b1;
                            res_status_next = cfr_pkg::STS_HDR_SAME;
                            if (new_frame)
                            begin
                                // The result goes out now; the sweep holds back later items.
                                active_id_next = cmd.frame_num;
                                expected_next = cmd.fsize;
                                count_next = '0;
                                res_status_next = cfr_pkg::STS_HDR_NEW;
                            end
                        end
                        cfr_pkg::OP_PAY:
                        begin
                            if (left_reg == 16'd0)
                            begin
                                done_next = 1'b1;
                                res_status_next = cfr_pkg::STS_DROP;
                            end
                            else if (pos_ok)
                            begin
                                ram_re = 1'b1;
                            end
                            else
                            begin
                                // Past the end of the store: counts as a duplicate.
                                done_next = 1'b1;
                                res_status_next = cfr_pkg::STS_DUP;
                                wpos_next = wpos_reg + PW'(1);
                                left_next = left_dec;
                                if (left_dec == 16'd0 && count_reg == expected_reg)
                                begin
                                    res_complete_next = 1'b1;
                                    ready_flag_next = 1'b1;
                                end
                            end
                        end
                        cfr_pkg::OP_READ:
                        begin
                            ram_raddr = cmd.raddr;
                            if (cmd.raddr_ok)
                            begin
                                ram_re = 1'b1;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                res_status_next = cfr_pkg::STS_READ;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            res_status_next = cfr_pkg::STS_DROP;
                        end
                    endcase
                end
            end
            cfr_pkg::S_PAY_WAIT:
            begin
                done_next = 1'b1;
                ram_waddr = wpos_reg[AW-1:0];
                ram_wdata = {1'b1, pay_byte_reg};
                ram_we = stored;
                count_next = count_inc;
                res_status_next = stored ? cfr_pkg::STS_STORED : cfr_pkg::STS_DUP;
                wpos_next = wpos_reg + PW'(1);
                left_next = left_dec;
                if (left_dec == 16'd0 && count_inc == expected_reg)
                begin
                    res_complete_next = 1'b1;
                    ready_flag_next = 1'b1;
                end
            end
            cfr_pkg::S_RD_WAIT:
            begin
                done_next = 1'b1;
                res_status_next = cfr_pkg::STS_READ;
                res_data_next = ram_rdata[cfr_pkg::STORE_W-1] ? ram_rdata[7:0] : 8'd0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pay_byte_reg <= pay_byte_next;
        res_data_reg <= res_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cfr_pkg::S_CLEAR;
            active_id_reg    <= '0;
            expected_reg     <= '0;
            count_reg        <= '0;
            wpos_reg         <= '0;
            left_reg         <= '0;
            ready_flag_reg   <= 1'b0;
            init_reg         <= 1'b1;
            clr_addr_reg     <= '0;
            done_reg         <= 1'b0;
            res_status_reg   <= cfr_pkg::STS_DROP;
            res_reason_reg   <= cfr_pkg::RSN_NONE;
            res_complete_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            active_id_reg    <= active_id_next;
            expected_reg     <= expected_next;
            count_reg        <= count_next;
            wpos_reg         <= wpos_next;
            left_reg         <= left_next;
            ready_flag_reg   <= ready_flag_next;
            init_reg         <= init_next;
            clr_addr_reg     <= clr_addr_next;
            done_reg         <= done_next;
            res_status_reg   <= res_status_next;
            res_reason_reg   <= res_reason_next;
            res_complete_reg <= res_complete_next;
        end
    end

    assign done           = done_reg;
    assign status         = res_status_reg;
    assign reject_reason  = res_reason_reg;
    assign frame_complete = res_complete_reg;
    assign current_frame  = active_id_reg;
    assign bytes_received = cfr_pkg::cnt_out(count_reg);
    assign frame_ready    = ready_flag_reg;
    assign read_data      = res_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/chunked_frame_reassembler.sv =====
// Top level of the chunked frame reassembler: front, queue and back joined.
// Depends on cfr_pkg, cfr_front, cfr_queue and cfr_back.
//
// Usage:
//   Input beats are commands: one is taken at a rising edge where start is high
//   and busy is low. func selects a chunk header, a payload byte or a read.
//   Every beat yields exactly one result, shown for one cycle with done high.
//   The receiver cannot stall; results are never held back or repeated.
// Result timing:
//   Headers, dropped bytes and unused codes show done once the beat has passed
//   the queue and the registered result of the back end; stored or duplicate
//   bytes and reads also pass the wait state for the registered read of the
//   byte store. The back end finishes one item per cycle (headers, drops) while
//   no sweep runs; a store access holds it in its wait state before the next
//   item. A two-entry queue lets the front keep taking beats meanwhile.
// Store sweeps:
//   After reset, and after each header that opens a new frame, the back end
//   writes zero to all MAX_FRAME store words, one per cycle.
//   During the sweep after reset busy stays high; during a new-frame sweep
//   beats are queued and busy rises once the queue is full.
`default_nettype none

module chunked_frame_reassembler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [15:0] packet_len,
    input  wire logic [31:0] magic_word,
    input  wire logic [31:0] frame_number,
    input  wire logic [31:0] frame_size,
    input  wire logic [31:0] chunk_offset,
    input  wire logic [15:0] chunk_size,
    input  wire logic [7:0]  payload_byte,
    input  wire logic [15:0] read_addr,
    output logic             done,
    output logic [2:0]       status,
    output logic [2:0]       reject_reason,
    output logic             frame_complete,
    output logic [31:0]      current_frame,
    output logic [16:0]      bytes_received,
    output logic             frame_ready,
    output logic [7:0]       read_data
);

    logic                push;
    logic                q_valid;
    logic                q_full;
    cfr_pkg::cmd_t       front_cmd;
    cfr_pkg::cmd_t       q_cmd;
    cfr_pkg::back_stat_t back_stat;

    assign busy = q_full || back_stat.init_busy;

    cfr_front u_front (
        .start        (start),
        .busy         (busy),
        .func         (func),
        .packet_len   (packet_len),
        .magic_word   (magic_word),
        .frame_number (frame_number),
        .frame_size   (frame_size),
        .chunk_offset (chunk_offset),
        .chunk_size   (chunk_size),
        .payload_byte (payload_byte),
        .read_addr    (read_addr),
        .push         (push),
        .cmd          (front_cmd)
    );

    cfr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (front_cmd),
        .pop     (back_stat.pop),
        .valid   (q_valid),
        .full    (q_full),
        .cmd_out (q_cmd)
    );

    cfr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .cmd            (q_cmd),
        .stat           (back_stat),
        .done           (done),
        .status         (status),
        .reject_reason  (reject_reason),
        .frame_complete (frame_complete),
        .current_frame  (current_frame),
        .bytes_received (bytes_received),
        .frame_ready    (frame_ready),
        .read_data      (read_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/cfr_checker.sv =====
// Port-level checks for the chunked frame reassembler, bound to the top level.
// Depends on cfr_pkg.
`default_nettype none

module cfr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        done,
    input wire logic [2:0]  status,
    input wire logic        frame_complete,
    input wire logic [16:0] bytes_received,
    input wire logic        frame_ready,
    input wire logic [7:0]  read_data
);

    // The frame-ready flag never drops once set.
    a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        frame_ready |=> frame_ready)
        else $error("frame_ready fell");

    a_complete_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
        done && frame_complete |-> frame_ready)
        else $error("completed frame without frame_ready");

    a_complete_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
        done && frame_complete |->
            (status == cfr_pkg::STS_STORED || status == cfr_pkg::STS_DUP))
        else $error("frame_complete on a non-payload result");

    a_new_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == cfr_pkg::STS_HDR_NEW |-> bytes_received == 17'd0)
        else $error("new frame with nonzero byte count");

    a_data_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != cfr_pkg::STS_READ |-> read_data == 8'd0)
        else $error("read_data nonzero on a non-read result");

endmodule

bind chunked_frame_reassembler cfr_checker u_cfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .done           (done),
    .status         (status),
    .frame_complete (frame_complete),
    .bytes_received (bytes_received),
    .frame_ready    (frame_ready),
    .read_data      (read_data)
);

`default_nettype wire

// ===== tb/reassembly_checker.sv =====
// Scoreboard for the chunked frame reassembler: predicts one result beat per
// accepted command beat and compares it field by field with what the block reports.
// Depends on cfr_pkg for the status and reason codes, the function codes and the sizes.

module reassembly_checker
    import cfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  func,
    input  logic [15:0] packet_len,
    input  logic [31:0] magic_word,
    input  logic [31:0] frame_number,
    input  logic [31:0] frame_size,
    input  logic [31:0] chunk_offset,
    input  logic [15:0] chunk_size,
    input  logic [7:0]  payload_byte,
    input  logic [15:0] read_addr,
    input  logic        done,
    input  logic [2:0]  status,
    input  logic [2:0]  reject_reason,
    input  logic        frame_complete,
    input  logic [31:0] current_frame,
    input  logic [16:0] bytes_received,
    input  logic        frame_ready,
    input  logic [7:0]  read_data,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        status_e     status;
        reason_e     reason;
        logic        complete;
        logic [31:0] frame;
        logic [16:0] count;
        logic        ready;
        logic [7:0]  rdata;
    } frame_result_t;

    frame_result_t expected_results[$];

    logic [7:0]  frame_bytes [MAX_FRAME];
    bit          seen_bits [MAX_FRAME];
    logic [31:0] active_id;
    logic [31:0] frame_len;
    logic [31:0] byte_count;
    logic [31:0] write_pos;
    logic [15:0] chunk_left;
    logic        frame_done;
    int          fail_count = 0;

    // The first failing check decides the reason; offset plus size is
    // compared in 33 bits so that it cannot wrap.
    function automatic reason_e header_verdict(input logic [15:0] plen,
                                               input logic [31:0] magic,
                                               input logic [31:0] fsize,
                                               input logic [31:0] offset,
                                               input logic [15:0] csize);
        logic [32:0] reach;
        reach = {1'b0, offset} + {17'b0, csize};
        if ({1'b0, plen} < HDR_BYTES)
            return RSN_SHORT;
        if (magic != HDR_MAGIC)
            return RSN_MAGIC;
        if (csize == 16'd0)
            return RSN_ZERO;
        if (HDR_BYTES + {1'b0, csize} > {1'b0, plen})
            return RSN_PKT;
        if (fsize == 32'd0 || fsize > 32'(MAX_FRAME))
            return RSN_SIZE;
        if (reach > {1'b0, fsize})
            return RSN_BEYOND;
        return RSN_NONE;
    endfunction

    task automatic wipe_store();
        for (int i = 0; i < MAX_FRAME; i++)
        begin
            frame_bytes[i] = '0;
            seen_bits[i]   = 1'b0;
        end
    endtask

    task automatic predict_beat();
        frame_result_t r;
        reason_e       why;
        r.status   = STS_DROP;
        r.reason   = RSN_NONE;
        r.complete = 1'b0;
        r.rdata    = '0;
        case (func)
            FN_HDR:
            begin
                why = header_verdict(packet_len, magic_word, frame_size, chunk_offset,
                                     chunk_size);
                if (why != RSN_NONE)
                begin
                    r.status   = STS_HDR_REJ;
                    r.reason   = why;
                    chunk_left = '0;
                end
                else
                begin
                    if (frame_number != active_id || frame_size != frame_len)
                    begin
                        active_id  = frame_number;
                        frame_len  = frame_size;
                        byte_count = '0;
                        wipe_store();
                        r.status = STS_HDR_NEW;
                    end
                    else
                    begin
                        r.status = STS_HDR_SAME;
                    end
                    write_pos  = chunk_offset;
                    chunk_left = chunk_size;
                end
            end
            FN_PAY:
            begin
                if (chunk_left != 16'd0)
                begin
                    if (write_pos < 32'(MAX_FRAME) && !seen_bits[write_pos[ADDR_W-1:0]])
                    begin
                        frame_bytes[write_pos[ADDR_W-1:0]] = payload_byte;
                        seen_bits[write_pos[ADDR_W-1:0]]   = 1'b1;
                        byte_count++;
                        r.status = STS_STORED;
                    end
                    else
                    begin
                        r.status = STS_DUP;
                    end
                    write_pos++;
                    chunk_left--;
                    if (chunk_left == 16'd0 && byte_count == frame_len)
                    begin
                        r.complete = 1'b1;
                        frame_done = 1'b1;
                    end
                end
            end
            FN_READ:
            begin
                r.status = STS_READ;
                if (32'(read_addr) < 32'(MAX_FRAME) && seen_bits[read_addr[ADDR_W-1:0]])
                    r.rdata = frame_bytes[read_addr[ADDR_W-1:0]];
            end
            default:
            begin
                // The unused function code leaves everything as it is.
            end
        endcase
        r.frame = active_id;
        r.count = byte_count[16:0];
        r.ready = frame_done;
        expected_results = {expected_results, r};
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic compare_result();
        frame_result_t r;
        if (expected_results.size() == 0)
        begin
            $error("result beat with no prediction waiting");
            fail_count++;
        end
        else
        begin
            r = expected_results.pop_front();
            check_field("status", 32'(r.status), 32'(status));
            check_field("reject_reason", 32'(r.reason), 32'(reject_reason));
            check_field("frame_complete", 32'(r.complete), 32'(frame_complete));
            check_field("current_frame", r.frame, current_frame);
            check_field("bytes_received", 32'(r.count), 32'(bytes_received));
            check_field("frame_ready", 32'(r.ready), 32'(frame_ready));
            check_field("read_data", 32'(r.rdata), 32'(read_data));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            wipe_store();
            active_id  = '0;
            frame_len  = '0;
            byte_count = '0;
            write_pos  = '0;
            chunk_left = '0;
            frame_done = 1'b0;
            pending    <= 0;
            mismatches <= 0;
        end
        else
        begin
            // A result beat always belongs to an older command, so it is
            // matched before this edge's command is predicted.
            if (done)
                compare_result();
            if (start && !busy)
                predict_beat();
            pending    <= expected_results.size();
            mismatches <= fail_count;
        end
    end

endmodule

// ===== tb/chunked_frame_reassembler_test.sv =====
// Top of the chunked frame reassembler testbench: clock, reset and command beats.
// Depends on cfr_pkg, the block chunked_frame_reassembler and reassembly_checker.

module chunked_frame_reassembler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cfr_pkg::*;

    localparam logic [1:0] FN_UNUSED  = 2'd3;
    localparam int         DRAIN_CAP  = 300000;

    typedef struct {
        logic [1:0]  func;
        logic [15:0] packet_len;
        logic [31:0] magic_word;
        logic [31:0] frame_number;
        logic [31:0] frame_size;
        logic [31:0] chunk_offset;
        logic [15:0] chunk_size;
        logic [7:0]  payload_byte;
        logic [15:0] read_addr;
    } cmd_beat_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic [1:0]  func         = '0;
    logic [15:0] packet_len   = '0;
    logic [31:0] magic_word   = '0;
    logic [31:0] frame_number = '0;
    logic [31:0] frame_size   = '0;
    logic [31:0] chunk_offset = '0;
    logic [15:0] chunk_size   = '0;
    logic [7:0]  payload_byte = '0;
    logic [15:0] read_addr    = '0;

    wire logic        busy;
    wire logic        done;
    wire logic [2:0]  status;
    wire logic [2:0]  reject_reason;
    wire logic        frame_complete;
    wire logic [31:0] current_frame;
    wire logic [16:0] bytes_received;
    wire logic        frame_ready;
    wire logic [7:0]  read_data;

    int mismatches;
    int pending;

    int          idle_pct   = 18;
    int          beats_sent = 0;
    logic [31:0] cur_id     = '0;
    logic [31:0] cur_size   = '0;

    chunked_frame_reassembler u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .packet_len     (packet_len),
        .magic_word     (magic_word),
        .frame_number   (frame_number),
        .frame_size     (frame_size),
        .chunk_offset   (chunk_offset),
        .chunk_size     (chunk_size),
        .payload_byte   (payload_byte),
        .read_addr      (read_addr),
        .done           (done),
        .status         (status),
        .reject_reason  (reject_reason),
        .frame_complete (frame_complete),
        .current_frame  (current_frame),
        .bytes_received (bytes_received),
        .frame_ready    (frame_ready),
        .read_data      (read_data)
    );

    reassembly_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .packet_len     (packet_len),
        .magic_word     (magic_word),
        .frame_number   (frame_number),
        .frame_size     (frame_size),
        .chunk_offset   (chunk_offset),
        .chunk_size     (chunk_size),
        .payload_byte   (payload_byte),
        .read_addr      (read_addr),
        .done           (done),
        .status         (status),
        .reject_reason  (reject_reason),
        .frame_complete (frame_complete),
        .current_frame  (current_frame),
        .bytes_received (bytes_received),
        .frame_ready    (frame_ready),
        .read_data      (read_data),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Fields a command does not use still carry random values.
    function automatic cmd_beat_t random_beat();
        cmd_beat_t b;
        b.func         = 2'($urandom);
        b.packet_len   = 16'($urandom);
        b.magic_word   = $urandom;
        b.frame_number = $urandom;
        b.frame_size   = $urandom;
        b.chunk_offset = $urandom;
        b.chunk_size   = 16'($urandom);
        b.payload_byte = 8'($urandom);
        b.read_addr    = 16'($urandom);
        return b;
    endfunction

    function automatic cmd_beat_t mk_header(input logic [31:0] fid, input logic [31:0] fsize,
                                            input logic [31:0] off, input logic [15:0] cs,
                                            input logic [15:0] plen);
        cmd_beat_t b;
        b = random_beat();
        b.func         = FN_HDR;
        b.magic_word   = HDR_MAGIC;
        b.frame_number = fid;
        b.frame_size   = fsize;
        b.chunk_offset = off;
        b.chunk_size   = cs;
        b.packet_len   = plen;
        return b;
    endfunction

    function automatic cmd_beat_t mk_payload(input logic [7:0] data);
        cmd_beat_t b;
        b = random_beat();
        b.func         = FN_PAY;
        b.payload_byte = data;
        return b;
    endfunction

    function automatic cmd_beat_t mk_read(input logic [15:0] addr);
        cmd_beat_t b;
        b = random_beat();
        b.func      = FN_READ;
        b.read_addr = addr;
        return b;
    endfunction

    // Start stays high from one beat to the next unless a gap lowers it.
    task automatic send(input cmd_beat_t b);
        start        <= 1'b1;
        func         <= b.func;
        packet_len   <= b.packet_len;
        magic_word   <= b.magic_word;
        frame_number <= b.frame_number;
        frame_size   <= b.frame_size;
        chunk_offset <= b.chunk_offset;
        chunk_size   <= b.chunk_size;
        payload_byte <= b.payload_byte;
        read_addr    <= b.read_addr;
        do @(posedge clk); while (busy);
        if (b.func != FN_UNUSED)
            beats_sent++;
    endtask

    task automatic issue(input cmd_beat_t b);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        send(b);
    endtask

    // A valid header for the current frame followed by its bytes; now and
    // then the chunk is cut short and left to the next header.
    task automatic send_chunk();
        int unsigned off;
        int unsigned cs;
        int unsigned n;
        bit          burst;
        off = $urandom_range(0, cur_size - 1);
        cs  = $urandom_range(1, (cur_size - off > 16) ? 16 : cur_size - off);
        issue(mk_header(cur_id, cur_size, off, 16'(cs),
                        16'(HDR_BYTES + cs + $urandom_range(0, 40))));
        n     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cs - 1) : cs;
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
        begin
            if (burst)
                send(mk_payload(8'($urandom)));
            else
                issue(mk_payload(8'($urandom)));
        end
    endtask

    // Each header fails at least the check its kind names, so it never
    // opens a frame and never starts a store sweep.
    task automatic send_bad_header();
        cmd_beat_t b;
        reason_e   kind;
        b = random_beat();
        b.func = FN_HDR;
        kind = reason_e'($urandom_range(1, 6));
        if (kind != RSN_SHORT && kind != RSN_MAGIC)
            b.magic_word = HDR_MAGIC;
        case (kind)
            RSN_SHORT:
                b.packet_len = 16'($urandom_range(0, 17));
            RSN_MAGIC:
            begin
                b.packet_len = 16'($urandom_range(18, 65535));
                if (b.magic_word == HDR_MAGIC)
                    b.magic_word = ~HDR_MAGIC;
            end
            RSN_ZERO:
            begin
                b.packet_len = 16'($urandom_range(18, 65535));
                b.chunk_size = '0;
            end
            RSN_PKT:
            begin
                b.packet_len = 16'($urandom_range(18, 65534));
                b.chunk_size = 16'($urandom_range(b.packet_len - 17, 65535));
            end
            RSN_SIZE:
            begin
                b.chunk_size = 16'($urandom_range(1, 64));
                b.packet_len = 16'(HDR_BYTES + b.chunk_size);
                b.frame_size = ($urandom_range(0, 1) == 0) ? 32'd0
                               : $urandom_range(MAX_FRAME + 1, 32'hFFFF_FFFF);
            end
            default:
            begin
                b.chunk_size = 16'($urandom_range(1, 64));
                b.packet_len = 16'(HDR_BYTES + b.chunk_size + $urandom_range(0, 100));
                b.frame_size = $urandom_range(1, MAX_FRAME);
                if (b.chunk_offset < b.frame_size)
                    b.chunk_offset = b.frame_size;
            end
        endcase
        issue(b);
    endtask

    task automatic run_frame(input int quota);
        cmd_beat_t   b;
        logic [31:0] fid;
        int          stop_at;
        int unsigned pick;
        // Hold off until every result is back before opening a new frame.
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        cur_size = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 300)
                                               : $urandom_range(1, 48);
        fid = $urandom;
        if (fid == cur_id)
            fid = ~fid;
        cur_id = fid;
        send_chunk();
        stop_at = beats_sent + quota;
        while (beats_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_chunk();
            else if (pick < 75)
                issue(mk_read(($urandom_range(0, 4) == 0) ? 16'($urandom)
                              : 16'($urandom_range(0, cur_size - 1))));
            else if (pick < 88)
            begin
                send_bad_header();
                repeat ($urandom_range(0, 2)) issue(mk_payload(8'($urandom)));
            end
            else if (pick < 94)
            begin
                b = random_beat();
                b.func = FN_UNUSED;
                issue(b);
            end
            else
            begin
                issue(mk_payload(8'($urandom)));
            end
        end
    endtask

    initial
    begin
        int waited;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats: reads and a stray byte on the empty store, the
        // unused code, every reject reason, then a full-size frame and a small frame.
        issue(mk_read(16'h0000));
        issue(mk_read(16'hFFFF));
        issue(mk_payload(8'hC3));
        issue('{FN_UNUSED, 16'hFFFF, HDR_MAGIC, 32'd7, 32'd8, 32'd0, 16'd1, 8'hFF, 16'd0});
        issue(mk_header(32'd5, 32'd1, 32'd0, 16'd1, 16'd17));
        begin
            cmd_beat_t b;
            b = mk_header(32'd5, 32'd1, 32'd0, 16'd1, 16'd19);
            b.magic_word = 32'hFFFF_FFFF;
            issue(b);
        end
        issue(mk_header(32'd5, 32'd1, 32'd0, 16'd0, 16'd18));
        issue(mk_header(32'd5, 32'd1, 32'd0, 16'hFFFF, 16'hFFFF));
        issue(mk_header(32'd5, 32'd0, 32'd0, 16'd1, 16'd19));
        issue(mk_header(32'd5, MAX_FRAME + 1, 32'd0, 16'd1, 16'd19));
        // Offset plus size would wrap to zero in 32 bits.
        issue(mk_header(32'd5, MAX_FRAME, 32'hFFFF_FFFF, 16'd1, 16'd19));
        issue(mk_payload(8'h11));
        cur_id   = 32'hFFFF_FFFF;
        cur_size = MAX_FRAME;
        issue(mk_header(cur_id, cur_size, MAX_FRAME - 4, 16'd4, 16'd22));
        issue(mk_payload(8'h00));
        issue(mk_payload(8'hFF));
        issue(mk_payload(8'hA5));
        issue(mk_payload(8'h5A));
        issue(mk_header(cur_id, cur_size, MAX_FRAME - 2, 16'd2, 16'hFFFF));
        issue(mk_payload(8'h77));
        issue(mk_payload(8'h88));
        issue(mk_read(16'hFFFF));
        // Largest chunk a full packet carries; a new header abandons it.
        issue(mk_header(cur_id, cur_size, 32'd0, 16'hFFED, 16'hFFFF));
        issue(mk_payload(8'h3C));
        cur_id   = 32'd1;
        cur_size = 32'd3;
        issue(mk_header(cur_id, cur_size, 32'd0, 16'd2, 16'd20));
        issue(mk_payload(8'h01));
        issue(mk_payload(8'h02));
        issue(mk_header(cur_id, cur_size, 32'd2, 16'd1, 16'd19));
        issue(mk_payload(8'h03));
        issue(mk_read(16'd2));

        for (int mode = 0; mode < 3; mode++)
        begin
            idle_pct = (mode == 0) ? 18 : (mode == 1) ? 57 : 0;
            for (int k = 0; k < 2; k++)
                run_frame(330);
        end

        start <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pending != 0 && waited < DRAIN_CAP);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_ram.sv
hw/rtl/cfr_front.sv
hw/rtl/cfr_queue.sv
hw/rtl/cfr_back.sv
hw/rtl/chunked_frame_reassembler.sv
hw/rtl/cfr_checker.sv
tb/reassembly_checker.sv
tb/chunked_frame_reassembler_test.sv
